@@ sv/ssu_pkg.sv @@
`default_nettype none
package ssu_pkg;

    localparam int MAX_REACTIONS = 16;
    localparam int MAX_SPECIES   = 16;
    localparam int RIDX_W        = $clog2(MAX_REACTIONS);
    localparam int SIDX_W        = $clog2(MAX_SPECIES);
    localparam int CNT_W         = 32;
    localparam int PROP_W        = 64;
    localparam int TIME_W        = 48;
    localparam int MUL_A_W       = 64;
    localparam int MUL_B_W       = 32;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;

    typedef enum logic [1:0] {
        OP_STOICH = 2'd0,
        OP_RATE   = 2'd1,
        OP_COUNT  = 2'd2,
        OP_STEP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_REACTIONS = 2'd0,
        CFG_SPECIES   = 2'd1,
        CFG_TIME_LIM  = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_index;

    typedef enum logic [4:0] {
        ST_IDLE, ST_REACT, ST_READ, ST_EVAL, ST_FACT, ST_FACT_W, ST_RATE, ST_RATE_W,
        ST_CHECK, ST_THR, ST_THR_W, ST_SCAN, ST_UPD_RD, ST_UPD, ST_DIV, ST_FIN, ST_OUT
    } t_state;

endpackage
`default_nettype wire

@@ sv/ssu_mul.sv @@
`default_nettype none
// 64 x 32 multiplier built from one 32 x 32 product used twice.
module ssu_mul
    import ssu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic                    o_done,
    output logic [MUL_P_W-1:0]      o_p
);

    logic [1:0]         r_cnt;
    logic               r_done;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [63:0]        r_lo;
    logic [63:0]        r_hi;
    logic [MUL_P_W-1:0] r_p;
    logic [31:0]        w_half;
    logic [63:0]        w_prod;

    assign w_half = (r_cnt == 2'd1) ? r_a[31:0] : r_a[63:32];
    assign w_prod = w_half * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 2'd3);
            if (i_start) begin
                r_cnt <= 2'd1;
            end else if (r_cnt != 2'd0) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_cnt == 2'd1) begin
            r_lo <= w_prod;
        end
        if (r_cnt == 2'd2) begin
            r_hi <= w_prod;
        end
        if (r_cnt == 2'd3) begin
            r_p <= {r_hi, 32'd0} + {32'd0, r_lo};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule
`default_nettype wire

@@ sv/stochastic_simulation_step_unit.sv @@
`default_nettype none
// One step of the direct stochastic simulation method. Beats with opcode write
// stoichiometry, rate or count return an acknowledge beat. A step beat walks
// every reaction and species in use through one shared 64 x 32 multiplier: per
// reaction a set-up state and a rate product, per species a read and an evaluation
// state plus one product per reactant factor, then a stop check. Unless the step
// stops, a threshold product, a scan over the reactions, a count update per species,
// a restoring divider for the time step and an add of it follow. Last the result
// register is loaded. The input is not ready while a beat is being worked on;
// the output register lets the next beat be accepted while the previous result
// still waits.
module stochastic_simulation_step_unit
    import ssu_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // reaction_index[3:0], species_index[7:4], stoich_value[12:8], rate_value[44:13],
    // count_value[76:45], uniform_draw[108:77], exp_draw[140:109], zero fill above
    input  wire logic [143:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // selected_reaction[3:0], total_propensity[67:4], time_now[115:68],
    // stopped[116], zero fill above
    output logic [119:0]       m_axis_tdata,
    // step_done[0]
    output logic [0:0]         m_axis_tuser
);

    t_state r_state, n_state;

    // Configuration
    logic [4:0]          r_nr, r_ns;
    logic [TIME_W-1:0]   r_tlim;

    // Model state
    logic [CNT_W-1:0]    r_counts [MAX_SPECIES];
    logic [31:0]         r_rates  [MAX_REACTIONS];
    logic [PROP_W-1:0]   r_cum    [MAX_REACTIONS];
    logic [4:0]          r_stm    [MAX_REACTIONS*MAX_SPECIES];
    logic [MAX_REACTIONS*MAX_SPECIES-1:0] r_stv;
    logic [TIME_W-1:0]   r_elapsed;

    // Working registers
    logic [31:0]         r_u, r_ex;
    logic [RIDX_W-1:0]   r_i, r_sel;
    logic [SIDX_W-1:0]   r_j;
    logic [4:0]          r_k, r_need, r_sq;
    logic [PROP_W-1:0]   r_prod, r_run, r_thr;
    logic                r_stop, r_isstep;
    logic [PROP_W:0]     r_rem;
    logic [39:0]         r_quo;
    logic [5:0]          r_dcnt;

    // Output register
    logic                r_ovalid;
    logic [3:0]          r_osel;
    logic [PROP_W-1:0]   r_ototal;
    logic [TIME_W-1:0]   r_otime;
    logic                r_ostop, r_odone;

    logic                w_accept;
    t_opcode             w_op;
    logic [RIDX_W-1:0]   w_ri;
    logic [SIDX_W-1:0]   w_si;
    logic [4:0]          w_nr, w_ns, w_need;
    logic                w_i_last, w_j_last, w_neg, w_enough, w_stop, w_hit, w_fire;
    logic [CNT_W-1:0]    w_cnt, w_fact, w_upd;
    logic [33:0]         w_csum;
    logic [PROP_W-1:0]   w_msat, w_run_next;
    logic [PROP_W:0]     w_rsum, w_rem_sh;
    logic                w_rem_ge;
    logic [TIME_W:0]     w_tsum;
    logic [RIDX_W+SIDX_W-1:0] w_st_addr;

    logic                w_mstart, w_mdone;
    logic [MUL_A_W-1:0]  w_ma;
    logic [MUL_B_W-1:0]  w_mb;
    logic [MUL_P_W-1:0]  w_mp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_opcode'(s_axis_tuser);
    assign w_ri          = s_axis_tdata[3:0];
    assign w_si          = s_axis_tdata[7:4];

    // Register values above the table size act as the table size.
    assign w_nr = (r_nr > 5'(MAX_REACTIONS)) ? 5'(MAX_REACTIONS) : r_nr;
    assign w_ns = (r_ns > 5'(MAX_SPECIES))   ? 5'(MAX_SPECIES)   : r_ns;
    assign w_i_last = ({1'b0, r_i} == w_nr - 5'd1);
    assign w_j_last = ({1'b0, r_j} == w_ns - 5'd1);

    // Reactant test: a negative entry s asks for -s molecules.
    assign w_neg    = r_sq[4];
    assign w_need   = (~r_sq) + 5'd1;
    assign w_cnt    = r_counts[r_j];
    assign w_enough = (w_cnt >= {27'd0, w_need});
    assign w_fact   = w_cnt - {27'd0, r_k};

    assign w_msat     = (w_mp[95:64] != 32'd0) ? '1 : w_mp[63:0];
    assign w_rsum     = {1'b0, r_run} + {1'b0, w_msat};
    assign w_run_next = w_rsum[PROP_W] ? '1 : w_rsum[PROP_W-1:0];

    assign w_stop = (r_elapsed >= r_tlim) || (r_run == '0);
    assign w_hit  = (r_thr <= r_cum[r_i]);

    // Count update saturates at zero and at the top of the count range.
    assign w_csum = {2'b00, w_cnt} + {{29{r_sq[4]}}, r_sq};
    assign w_upd  = w_csum[33] ? '0 : (w_csum[32] ? '1 : w_csum[31:0]);

    // Restoring division, one quotient bit per cycle.
    assign w_rem_sh = {r_rem[PROP_W-1:0], r_quo[39]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_run});

    assign w_tsum = {1'b0, r_elapsed} + {9'd0, r_quo};
    assign w_fire = !r_ovalid || m_axis_tready;

    assign w_st_addr = {((r_state == ST_UPD_RD) || (r_state == ST_UPD)) ? r_sel : r_i, r_j};

    ssu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    // Operands for the shared multiplier.
    always_comb begin
        w_mstart = (r_state == ST_FACT) || (r_state == ST_RATE) || (r_state == ST_THR);
        w_ma     = (r_state == ST_THR) ? r_run : r_prod;
        case (r_state)
            ST_FACT: w_mb = w_fact;
            ST_RATE: w_mb = r_rates[r_i];
            default: w_mb = r_u;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_op != OP_STEP) begin
                        n_state = ST_OUT;
                    end else if (w_nr == 5'd0) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_REACT;
                    end
                end
            end
            ST_REACT:  n_state = (w_ns == 5'd0) ? ST_RATE : ST_READ;
            ST_READ:   n_state = ST_EVAL;
            ST_EVAL: begin
                if (w_neg && w_enough) begin
                    n_state = ST_FACT;
                end else begin
                    n_state = w_j_last ? ST_RATE : ST_READ;
                end
            end
            ST_FACT:   n_state = ST_FACT_W;
            ST_FACT_W: begin
                if (w_mdone) begin
                    if (r_k + 5'd1 == r_need) begin
                        n_state = w_j_last ? ST_RATE : ST_READ;
                    end else begin
                        n_state = ST_FACT;
                    end
                end
            end
            ST_RATE:   n_state = ST_RATE_W;
            ST_RATE_W: begin
                if (w_mdone) begin
                    n_state = w_i_last ? ST_CHECK : ST_REACT;
                end
            end
            ST_CHECK:  n_state = w_stop ? ST_OUT : ST_THR;
            ST_THR:    n_state = ST_THR_W;
            ST_THR_W:  n_state = w_mdone ? ST_SCAN : ST_THR_W;
            ST_SCAN: begin
                if (w_hit || w_i_last) begin
                    n_state = (w_ns == 5'd0) ? ST_DIV : ST_UPD_RD;
                end
            end
            ST_UPD_RD: n_state = ST_UPD;
            ST_UPD:    n_state = w_j_last ? ST_DIV : ST_UPD_RD;
            ST_DIV:    n_state = (r_dcnt == 6'd39) ? ST_FIN : ST_DIV;
            ST_FIN:    n_state = ST_OUT;
            ST_OUT:    n_state = w_fire ? ST_IDLE : ST_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control and model state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_nr      <= 5'(MAX_REACTIONS);
            r_ns      <= 5'(MAX_SPECIES);
            r_tlim    <= '0;
            r_elapsed <= '0;
            r_stv     <= '0;
            for (int n = 0; n < MAX_SPECIES; n++) begin
                r_counts[n] <= '0;
            end
            for (int n = 0; n < MAX_REACTIONS; n++) begin
                r_rates[n] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_REACTIONS: r_nr   <= i_cfg_data[4:0];
                    CFG_SPECIES:   r_ns   <= i_cfg_data[4:0];
                    CFG_TIME_LIM:  r_tlim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                case (w_op)
                    OP_STOICH: r_stv[{w_ri, w_si}] <= 1'b1;
                    OP_RATE:   r_rates[w_ri]       <= s_axis_tdata[44:13];
                    OP_COUNT:  r_counts[w_si]      <= s_axis_tdata[76:45];
                    default: ;
                endcase
            end
            if (r_state == ST_UPD) begin
                r_counts[r_j] <= w_upd;
            end
            if (r_state == ST_FIN) begin
                r_elapsed <= w_tsum[TIME_W] ? '1 : w_tsum[TIME_W-1:0];
            end
            if ((r_state == ST_OUT) && w_fire) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Stoichiometry memory: an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_STOICH)) begin
            r_stm[{w_ri, w_si}] <= s_axis_tdata[12:8];
        end
        r_sq <= r_stv[w_st_addr] ? r_stm[w_st_addr] : 5'd0;
    end

    // Datapath of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_u      <= s_axis_tdata[108:77];
                r_ex     <= s_axis_tdata[140:109];
                r_sel    <= '0;
                r_stop   <= 1'b0;
                r_isstep <= (w_op == OP_STEP);
                r_run    <= '0;
                r_i      <= '0;
                r_j      <= '0;
                r_prod   <= 64'd1;
            end
            ST_REACT: begin
                r_j    <= '0;
                r_prod <= 64'd1;
            end
            ST_EVAL: begin
                r_need <= w_need;
                r_k    <= 5'd0;
                if (!(w_neg && w_enough)) begin
                    if (w_neg) begin
                        r_prod <= '0;
                    end
                    r_j <= r_j + 1'b1;
                end
            end
            ST_FACT_W: begin
                if (w_mdone) begin
                    r_prod <= w_msat;
                    r_k    <= r_k + 5'd1;
                    if (r_k + 5'd1 == r_need) begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            ST_RATE_W: begin
                if (w_mdone) begin
                    r_run      <= w_run_next;
                    r_cum[r_i] <= w_run_next;
                    r_i        <= r_i + 1'b1;
                end
            end
            ST_CHECK: begin
                r_stop <= w_stop;
            end
            ST_THR_W: begin
                r_thr <= w_mp[95:32];
                r_i   <= '0;
            end
            ST_SCAN: begin
                r_j    <= '0;
                r_rem  <= '0;
                r_quo  <= {r_ex, 8'd0};
                r_dcnt <= 6'd0;
                if (w_hit) begin
                    r_sel <= r_i;
                end else if (!w_i_last) begin
                    r_i <= r_i + 1'b1;
                end
            end
            ST_UPD: begin
                r_j <= r_j + 1'b1;
            end
            ST_DIV: begin
                r_rem  <= w_rem_ge ? (w_rem_sh - {1'b0, r_run}) : w_rem_sh;
                r_quo  <= {r_quo[38:0], w_rem_ge};
                r_dcnt <= r_dcnt + 6'd1;
            end
            default: ;
        endcase
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_fire) begin
            r_osel   <= r_sel;
            r_ototal <= r_run;
            r_otime  <= r_elapsed;
            r_ostop  <= r_stop;
            r_odone  <= r_isstep;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_ostop, r_otime, r_ototal, r_osel};
    assign m_axis_tuser  = r_odone;

endmodule
`default_nettype wire

@@ sv/ssu_chk.sv @@
`default_nettype none
module ssu_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [119:0] m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser
);

    // A waiting result beat stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Every accepted beat keeps the input busy for the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // An acknowledge carries no total, no stop and reaction zero.
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[67:4] == 64'd0 && !m_axis_tdata[116] && m_axis_tdata[3:0] == 4'd0)
        else $error("acknowledge beat carries step results");

endmodule

bind stochastic_simulation_step_unit ssu_chk u_ssu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
